// ===== sv/scf_pkg.sv =====
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types and fixed widths for the strip cluster finder.
// ----------------------------------------------------------------------------
package scf_pkg;

  // Fixed port widths
  localparam int CHARGE_BITS = 16;
  localparam int REGION_W    = 4;
  localparam int WIDTH_W     = 6;
  localparam int STRIP_OUT_W = 9;
  localparam int HALF_W      = 10;
  localparam int BARY_W      = 17;
  localparam int TOTAL_W     = 21;

  // Fraction bits of the barycentric centre
  localparam int FRAC_BITS = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } scf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic load_div;
    logic step_div;
    logic load_out;
  } scf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic close;
    logic div_last;
    logic out_free;
  } scf_status_t;

endpackage

// ===== sv/scf_ctrl.sv =====
// ----------------------------------------------------------------------------
// scf_ctrl
// Sequencer: strip intake, divider start, divider run, result hand-off.
// ----------------------------------------------------------------------------
module scf_ctrl import scf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  scf_status_t status,
  output scf_cmd_t    cmd
);

  scf_state_t state;
  scf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && status.close) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_div = 1'b1;
        state_next   = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.step_div = 1'b1;
        if (status.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/scf_datapath.sv =====
// ----------------------------------------------------------------------------
// scf_datapath
// Strip counters, run accumulators, restoring divider and result register.
// ----------------------------------------------------------------------------
module scf_datapath import scf_pkg::*; #(
  parameter int NUM_BLOCKS   = 12,
  parameter int BLOCK_STRIPS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  scf_cmd_t               cmd,
  output scf_status_t            status,
  input  logic [CHARGE_BITS-1:0] strip_charge,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CHARGE_BITS-1:0] cfg_data,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [REGION_W-1:0]    region,
  output logic [WIDTH_W-1:0]     width,
  output logic [STRIP_OUT_W-1:0] first_strip,
  output logic [STRIP_OUT_W-1:0] peak_strip,
  output logic [HALF_W-1:0]      half_strip_centre,
  output logic [STRIP_OUT_W-1:0] strip_centre,
  output logic [BARY_W-1:0]      bary_centre,
  output logic [TOTAL_W-1:0]     total_charge
);

  localparam int STRIP_W = $clog2(NUM_BLOCKS * BLOCK_STRIPS);
  localparam int BLK_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int POS_W   = $clog2(BLOCK_STRIPS);
  localparam int RUN_W   = $clog2(BLOCK_STRIPS + 1);
  localparam int SUM_W   = CHARGE_BITS + RUN_W;
  localparam int PROD_W  = CHARGE_BITS + STRIP_W;
  localparam int WSUM_W  = SUM_W + STRIP_W;
  localparam int QW      = STRIP_W + FRAC_BITS;
  localparam int CNT_W   = $clog2(QW);

  logic [CHARGE_BITS-1:0] threshold;

  logic [STRIP_W-1:0] strip_cnt;
  logic [BLK_W-1:0]   blk_cnt;
  logic [POS_W-1:0]   pos_cnt;

  logic                   cluster_open;
  logic [STRIP_W-1:0]     start_strip;
  logic [BLK_W-1:0]       start_blk;
  logic [RUN_W-1:0]       run_width;
  logic [SUM_W-1:0]       charge_sum;
  logic [WSUM_W-1:0]      moment_sum;
  logic [CHARGE_BITS-1:0] max_charge;
  logic [STRIP_W-1:0]     max_strip;

  logic [SUM_W-1:0] div_rem;
  logic [QW-1:0]    div_sr;
  logic [CNT_W-1:0] div_cnt;

  logic              above;
  logic              block_end;
  logic              blk_last;
  logic [PROD_W-1:0] prod;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;
  logic              quo_bit;

  logic [BLK_W:0]     region_full;
  logic [STRIP_W+1:0] half_full;
  logic [STRIP_W:0]   centre_full;

  assign above     = strip_charge > threshold;
  assign block_end = pos_cnt == POS_W'(BLOCK_STRIPS - 1);
  assign blk_last  = blk_cnt == BLK_W'(NUM_BLOCKS - 1);
  assign prod      = PROD_W'(strip_charge) * PROD_W'(strip_cnt);

  assign status.close    = cluster_open ? (!above || block_end) : (above && block_end);
  assign status.div_last = div_cnt == CNT_W'(QW - 1);
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // Strip position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      strip_cnt <= '0;
      blk_cnt   <= '0;
      pos_cnt   <= '0;
    end else if (cmd.accept) begin
      if (block_end) begin
        pos_cnt <= '0;
        if (blk_last) begin
          blk_cnt   <= '0;
          strip_cnt <= '0;
        end else begin
          blk_cnt   <= blk_cnt + BLK_W'(1);
          strip_cnt <= strip_cnt + STRIP_W'(1);
        end
      end else begin
        pos_cnt   <= pos_cnt + POS_W'(1);
        strip_cnt <= strip_cnt + STRIP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_open <= 1'b0;
    end else if (cmd.accept) begin
      cluster_open <= above && !block_end;
    end
  end

  // Run accumulators; hold their values through the divide after a close
  always_ff @(posedge clk) begin
    if (cmd.accept && above) begin
      if (!cluster_open) begin
        start_strip <= strip_cnt;
        start_blk   <= blk_cnt;
        run_width   <= RUN_W'(1);
        charge_sum  <= SUM_W'(strip_charge);
        moment_sum  <= WSUM_W'(prod);
        max_charge  <= strip_charge;
        max_strip   <= strip_cnt;
      end else begin
        run_width  <= run_width + RUN_W'(1);
        charge_sum <= charge_sum + SUM_W'(strip_charge);
        moment_sum <= moment_sum + WSUM_W'(prod);
        if (strip_charge > max_charge) begin
          max_charge <= strip_charge;
          max_strip  <= strip_cnt;
        end
      end
    end
  end

  // Restoring divider, one quotient bit per clock: (moment_sum << 8) / charge_sum.
  // moment_sum >> STRIP_W is always below charge_sum, so QW quotient bits suffice.
  assign trial   = {div_rem, div_sr[QW-1]};
  assign diff    = trial - {1'b0, charge_sum};
  assign quo_bit = trial >= {1'b0, charge_sum};

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      div_rem <= SUM_W'(moment_sum >> STRIP_W);
      div_sr  <= {moment_sum[STRIP_W-1:0], FRAC_BITS'(0)};
      div_cnt <= '0;
    end else if (cmd.step_div) begin
      div_rem <= quo_bit ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      div_sr  <= {div_sr[QW-2:0], quo_bit};
      div_cnt <= div_cnt + CNT_W'(1);
    end
  end

  assign region_full = (BLK_W + 1)'(NUM_BLOCKS) - {1'b0, start_blk};
  assign half_full   = {1'b0, start_strip, 1'b0} + (STRIP_W + 2)'(run_width)
                       - (STRIP_W + 2)'(1);
  assign centre_full = {1'b0, start_strip}
                       + (STRIP_W + 1)'((run_width - RUN_W'(1)) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      region            <= REGION_W'(region_full);
      width             <= WIDTH_W'(run_width);
      first_strip       <= STRIP_OUT_W'(start_strip);
      peak_strip        <= STRIP_OUT_W'(max_strip);
      half_strip_centre <= HALF_W'(half_full);
      strip_centre      <= STRIP_OUT_W'(centre_full);
      bary_centre       <= BARY_W'(div_sr);
      total_charge      <= TOTAL_W'(charge_sum);
    end
  end

  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result loaded over an untaken result");

  a_close_ends_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && status.close) |=> !cluster_open)
    else $error("run still open after close");

  a_run_width: assert property (@(posedge clk) disable iff (rst)
    cluster_open |-> (run_width != '0 && run_width < RUN_W'(BLOCK_STRIPS)))
    else $error("open run width out of range");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load_div |=> div_rem < charge_sum)
    else $error("divider partial remainder not below divisor");

endmodule

// ===== sv/strip_cluster_finder.sv =====
// ----------------------------------------------------------------------------
// strip_cluster_finder
// Streaming threshold clustering of strip charges with per-cluster centroids.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ------------------------------------------
//  in       in   in_valid / in_stall  strip_charge
//  out      out  out_valid/out_stall  region, width, first_strip, peak_strip,
//                                     half_strip_centre, strip_centre,
//                                     bary_centre, total_charge
//  cfg      in   cfg_valid/cfg_ready  cfg_data (threshold)
//
//  One strip transfer per clock while no cluster closes.
//  A closing strip stalls the input through a load state, the bit-serial
//  barycentre divider (one divider bit per clock) and a hand-off state.
//  A result waiting on out_stall holds only the next hand-off; strips keep
//  flowing until the next close, whose stall then lasts until the result
//  register frees.
//  Synchronous active-high reset clears counters, run state and threshold.
// ----------------------------------------------------------------------------
module strip_cluster_finder import scf_pkg::*; #(
  parameter int NUM_BLOCKS   = 12,
  parameter int BLOCK_STRIPS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // strip input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CHARGE_BITS-1:0] strip_charge,
  // threshold write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CHARGE_BITS-1:0] cfg_data,
  // cluster output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [REGION_W-1:0]    region,
  output logic [WIDTH_W-1:0]     width,
  output logic [STRIP_OUT_W-1:0] first_strip,
  output logic [STRIP_OUT_W-1:0] peak_strip,
  output logic [HALF_W-1:0]      half_strip_centre,
  output logic [STRIP_OUT_W-1:0] strip_centre,
  output logic [BARY_W-1:0]      bary_centre,
  output logic [TOTAL_W-1:0]     total_charge
);

  scf_cmd_t    cmd;
  scf_status_t status;

  // Threshold writes must arrive only while idle (unenforced); cfg_ready is 1.
  assign cfg_ready = 1'b1;

  // Controller: intake, divider sequencing, result hand-off
  scf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: counters, run accumulators, divider, result register
  scf_datapath #(
    .NUM_BLOCKS   (NUM_BLOCKS),
    .BLOCK_STRIPS (BLOCK_STRIPS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .strip_charge      (strip_charge),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .region            (region),
    .width             (width),
    .first_strip       (first_strip),
    .peak_strip        (peak_strip),
    .half_strip_centre (half_strip_centre),
    .strip_centre      (strip_centre),
    .bary_centre       (bary_centre),
    .total_charge      (total_charge)
  );

endmodule
